FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk; hold off while rst_n is low.
`define PBFG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that prop holds in the cycle after trig; hold off while rst_n is low.
`define PBFG_ASSERT_NEXT(name, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/pbfg_pkg.sv
`default_nettype none

package pbfg_pkg;

    // Queue between front and back; depth is a power of two.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Signed sum of four Q48.48 terms, its magnitude, and the rounded product.
    localparam int SUM_W  = 98;
    localparam int MAG_W  = 97;
    localparam int PROD_W = 130;

    // APB register map.
    localparam int PADDR_W = 3;
    localparam logic [0:0]  REG_INV_CELL_AREA   = 1'b0;
    localparam logic [31:0] INV_CELL_AREA_RESET = 32'd65536;

    // Saturation limits of the Q16.16 result.
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Corners in counter-clockwise order.
    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_BL = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_TR = 2'd3
    } corner_code_t;

    // One corner of a classified item: both weight factors and the node
    // value as magnitudes, with the combined sign of their product.
    typedef struct packed {
        logic [31:0] fa_mag;
        logic [31:0] fb_mag;
        logic [31:0] v_mag;
        logic        neg;
    } corner_t;

    typedef struct packed {
        corner_t [3:0] corner;
        logic [2:0]    comp;
    } gather_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/pic_bilinear_field_gather_core.sv
// Bilinear field gather: four area weights, weighted node sum, scale by 1/h^2, Q16.16 out.
// An accepted item passes the queue, the eight back stages and the output register before out_valid.
// Throughput: one item per cycle unless the output stalls; every multiplier stage is fully pipelined.
// Back pressure stalls the whole back pipe; a 4-entry queue keeps accepting until it is full.
// Reset (rst_n low, async): pipe and queue empty, inv_cell_area = 1.0 (65536).
`default_nettype none

module pic_bilinear_field_gather_core
    import pbfg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] cell_left,
    input  logic signed [31:0] cell_right,
    input  logic signed [31:0] cell_top,
    input  logic signed [31:0] cell_bottom,
    input  logic [1:0]         corner_order,
    input  logic signed [31:0] node_value_a,
    input  logic signed [31:0] node_value_b,
    input  logic signed [31:0] node_value_c,
    input  logic signed [31:0] node_value_d,
    input  logic [2:0]         component_index,
    // Result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         component_out,
    output logic signed [31:0] field_at_particle,
    output logic               saturated
);

    logic [31:0]  inv_cell_area_reg, inv_cell_area_next;
    logic         cfg_write;
    logic         push, pop;
    gather_item_t front_item, head_item;
    q_status_t    q_status;
    logic [31:0]  field_bits;

    // Configuration: a single word register, written in the APB access phase. Users must
    // keep the block idle during writes, as the back pipe reads it directly; no logic checks this.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[PADDR_W-1:2] == REG_INV_CELL_AREA);
    assign inv_cell_area_next = cfg_write ? pwdata : inv_cell_area_reg;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_INV_CELL_AREA) ? inv_cell_area_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_cell_area_reg <= INV_CELL_AREA_RESET;
        end
        else
        begin
            inv_cell_area_reg <= inv_cell_area_next;
        end
    end

    // Front: accept the item, form the edge differences, and sort the four
    // node values onto their corners as corner_order says.
    pbfg_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .cell_left       (cell_left),
        .cell_right      (cell_right),
        .cell_top        (cell_top),
        .cell_bottom     (cell_bottom),
        .corner_order    (corner_order),
        .node_value_a    (node_value_a),
        .node_value_b    (node_value_b),
        .node_value_c    (node_value_c),
        .node_value_d    (node_value_d),
        .component_index (component_index),
        .q_status        (q_status),
        .push            (push),
        .item            (front_item)
    );

    // Queue: decouple acceptance from the back pipe's stalls.
    pbfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // Back: eight stages of products, sums and rounding, then the output register, which
    // saturates. Pop whenever the pipe can advance and the queue holds an item.
    pbfg_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_status          (q_status),
        .head_item         (head_item),
        .pop               (pop),
        .inv_cell_area     (inv_cell_area_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .component_out     (component_out),
        .field_at_particle (field_bits),
        .saturated         (saturated)
    );

    assign field_at_particle = field_bits;

endmodule

`default_nettype wire

FILE: rtl/pbfg_queue.sv
`default_nettype none
`include "assert_macros.svh"

module pbfg_queue
    import pbfg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  gather_item_t push_item,
    input  logic         pop,
    output gather_item_t head_item,
    output q_status_t    status
);

    gather_item_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

    `PBFG_ASSERT(a_pop_has_item, pop |-> count_reg != '0, "pop from empty queue")
    `PBFG_ASSERT_NEXT(a_pop_drops_count, pop && !push,
                      count_reg == $past(count_reg) - QCNT_W'(1), "count did not drop on pop")

endmodule

`default_nettype wire

FILE: rtl/pbfg_front.sv
`default_nettype none

module pbfg_front
    import pbfg_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] cell_left,
    input  logic signed [31:0] cell_right,
    input  logic signed [31:0] cell_top,
    input  logic signed [31:0] cell_bottom,
    input  logic [1:0]         corner_order,
    input  logic signed [31:0] node_value_a,
    input  logic signed [31:0] node_value_b,
    input  logic signed [31:0] node_value_c,
    input  logic signed [31:0] node_value_d,
    input  logic [2:0]         component_index,
    input  q_status_t          q_status,
    output logic               push,
    output gather_item_t       item
);

    logic [32:0] dxr, dxl, dyt, dyb;
    logic [31:0] node [4];

    function automatic logic [31:0] mag33(input logic [32:0] d);
        logic [32:0] n;
        n = ~d + 33'd1;
        mag33 = d[32] ? n[31:0] : d[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] n;
        n = ~v + 32'd1;
        mag32 = v[31] ? n : v;
    endfunction

    // Exact 33-bit edge differences.
    assign dxr = {cell_right[31], cell_right} - {pos_x[31], pos_x};
    assign dxl = {pos_x[31], pos_x} - {cell_left[31], cell_left};
    assign dyt = {cell_top[31], cell_top} - {pos_y[31], pos_y};
    assign dyb = {pos_y[31], pos_y} - {cell_bottom[31], cell_bottom};

    assign node[0] = node_value_a;
    assign node[1] = node_value_b;
    assign node[2] = node_value_c;
    assign node[3] = node_value_d;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Sort the node values onto their corners and pick each corner's factors.
    always_comb
    begin
        logic [32:0]  fa, fb;
        logic [31:0]  v;
        logic [1:0]   idx;
        corner_code_t code;
        item.comp = component_index;
        for (int c = 0; c < 4; c++)
        begin
            code = corner_code_t'(2'(c));
            idx  = 2'(c) - corner_order;
            v    = node[idx];
            unique case (code)
                CORNER_TL: begin fa = dxr; fb = dyb; end
                CORNER_BL: begin fa = dxr; fb = dyt; end
                CORNER_BR: begin fa = dxl; fb = dyt; end
                CORNER_TR: begin fa = dxl; fb = dyb; end
                default:   begin fa = dxl; fb = dyb; end
            endcase
            item.corner[c].fa_mag = mag33(fa);
            item.corner[c].fb_mag = mag33(fb);
            item.corner[c].v_mag  = mag32(v);
            item.corner[c].neg    = fa[32] ^ fb[32] ^ v[31];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pbfg_back.sv
`default_nettype none
`include "assert_macros.svh"

module pbfg_back
    import pbfg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_status,
    input  gather_item_t head_item,
    output logic         pop,
    input  logic [31:0]  inv_cell_area,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   component_out,
    output logic [31:0]  field_at_particle,
    output logic         saturated
);

    localparam logic [PROD_W-1:0] ROUND_BIT = PROD_W'(1) << 47;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = {32'b0, a} * {32'b0, b};
    endfunction

    logic en;
    logic [7:0] stage_valid_reg, stage_valid_next;
    logic       out_valid_reg, out_valid_next;

    // Stage 1: weight magnitudes.
    logic [63:0] w_reg [4], w_next [4];
    logic [31:0] vmag_reg [4], vmag_next [4];
    logic [3:0]  neg1_reg, neg1_next;
    logic [2:0]  comp1_reg;
    // Stage 2: weight times value, two partial products.
    logic [63:0] pl_reg [4], pl_next [4];
    logic [63:0] ph_reg [4], ph_next [4];
    logic [3:0]  neg2_reg;
    logic [2:0]  comp2_reg;
    // Stage 3: merged term magnitudes.
    logic [95:0] t_reg [4], t_next [4];
    logic [3:0]  neg3_reg;
    logic [2:0]  comp3_reg;
    // Stage 4: pair sums.
    logic [SUM_W-1:0] term [4];
    logic [SUM_W-1:0] pair_reg [2], pair_next [2];
    logic [2:0]       comp4_reg;
    // Stage 5: total.
    logic [SUM_W-1:0] total_reg, total_next;
    logic [2:0]       comp5_reg;
    // Stage 6: sign and magnitude.
    logic [SUM_W-1:0] total_inv;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg6_reg, neg6_next;
    logic [2:0]       comp6_reg;
    // Stage 7: scale by inv_cell_area, limb products.
    logic [63:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic [31:0] p3_reg, p3_next;
    logic        neg7_reg;
    logic [2:0]  comp7_reg;
    // Stage 8: round.
    logic [PROD_W-1:0] prod;
    logic [63:0]       q_reg, q_next;
    logic              big_reg, big_next;
    logic              neg8_reg;
    logic [2:0]        comp8_reg;
    // Output register.
    logic [31:0] limit, clip;
    logic        sat_next;
    logic [31:0] field_reg, field_next;
    logic        sat_reg;
    logic [2:0]  comp_out_reg;

    // Advance the whole pipe unless a finished item waits at the output.
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !q_status.empty;

    assign stage_valid_next = en ? {stage_valid_reg[6:0], pop} : stage_valid_reg;
    assign out_valid_next   = en ? stage_valid_reg[7] : out_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            w_next[c]    = mul32(head_item.corner[c].fa_mag, head_item.corner[c].fb_mag);
            vmag_next[c] = head_item.corner[c].v_mag;
            neg1_next[c] = head_item.corner[c].neg;
            pl_next[c]   = mul32(w_reg[c][31:0], vmag_reg[c]);
            ph_next[c]   = mul32(w_reg[c][63:32], vmag_reg[c]);
            t_next[c]    = {32'b0, pl_reg[c]} + {ph_reg[c], 32'b0};
            term[c]      = {2'b0, t_reg[c]} ^ {SUM_W{neg3_reg[c]}};
        end
        // Negation folded in: negative terms inverted, plus one carry for each.
        pair_next[0] = term[0] + term[1] + SUM_W'(neg3_reg[0]) + SUM_W'(neg3_reg[1]);
        pair_next[1] = term[2] + term[3] + SUM_W'(neg3_reg[2]) + SUM_W'(neg3_reg[3]);
        total_next   = pair_reg[0] + pair_reg[1];
        total_inv    = ~total_reg + SUM_W'(1);
        neg6_next    = total_reg[SUM_W-1];
        mag_next     = neg6_next ? total_inv[MAG_W-1:0] : total_reg[MAG_W-1:0];
        p0_next      = mul32(mag_reg[31:0], inv_cell_area);
        p1_next      = mul32(mag_reg[63:32], inv_cell_area);
        p2_next      = mul32(mag_reg[95:64], inv_cell_area);
        p3_next      = mag_reg[MAG_W-1] ? inv_cell_area : 32'd0;
        // Round half away from zero on the magnitude, at Q16.16.
        prod         = {2'b0, p2_reg, p0_reg} + {2'b0, p3_reg, p1_reg, 32'b0} + ROUND_BIT;
        q_next       = prod[111:48];
        big_next     = |prod[PROD_W-1:112];
        limit        = neg8_reg ? SAT_NEG : SAT_POS;
        sat_next     = big_reg || (|q_reg[63:32]) || (q_reg[31:0] > limit);
        clip         = sat_next ? limit : q_reg[31:0];
        field_next   = neg8_reg ? (~clip + 32'd1) : clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                w_reg[c]    <= w_next[c];
                vmag_reg[c] <= vmag_next[c];
                pl_reg[c]   <= pl_next[c];
                ph_reg[c]   <= ph_next[c];
                t_reg[c]    <= t_next[c];
            end
            neg1_reg     <= neg1_next;
            comp1_reg    <= head_item.comp;
            neg2_reg     <= neg1_reg;
            comp2_reg    <= comp1_reg;
            neg3_reg     <= neg2_reg;
            comp3_reg    <= comp2_reg;
            pair_reg[0]  <= pair_next[0];
            pair_reg[1]  <= pair_next[1];
            comp4_reg    <= comp3_reg;
            total_reg    <= total_next;
            comp5_reg    <= comp4_reg;
            mag_reg      <= mag_next;
            neg6_reg     <= neg6_next;
            comp6_reg    <= comp5_reg;
            p0_reg       <= p0_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            neg7_reg     <= neg6_reg;
            comp7_reg    <= comp6_reg;
            q_reg        <= q_next;
            big_reg      <= big_next;
            neg8_reg     <= neg7_reg;
            comp8_reg    <= comp7_reg;
            field_reg    <= field_next;
            sat_reg      <= sat_next;
            comp_out_reg <= comp8_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign field_at_particle = field_reg;
    assign saturated         = sat_reg;
    assign component_out     = comp_out_reg;

    `PBFG_ASSERT(a_sat_at_limit, out_valid_reg && sat_reg |->
                 field_reg == SAT_POS || field_reg == SAT_NEG, "saturated result off limit")
    `PBFG_ASSERT_NEXT(a_stall_freezes_pipe, out_valid_reg && !out_ready,
                      $stable(stage_valid_reg), "pipe moved while output stalled")

endmodule

`default_nettype wire
